// ===== sv/rslp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rslp_pkg;

    // Default sizing of the pool.
    localparam int NUM_SLOTS_DEF      = 16;
    localparam int MAX_SLOT_BYTES_DEF = 4096;

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_ACQUIRE = 3'd0;
    localparam logic [2:0] KIND_RETAIN  = 3'd1;
    localparam logic [2:0] KIND_RELEASE = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_STATS   = 3'd4;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_STALE = 2'd1;
    localparam logic [1:0] STATUS_SIZE  = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    // Statistic counter indexes.
    localparam int         N_STATS     = 7;
    localparam logic [2:0] STAT_ACQ    = 3'd0;
    localparam logic [2:0] STAT_FAIL   = 3'd1;
    localparam logic [2:0] STAT_INUSE  = 3'd2;
    localparam logic [2:0] STAT_HIGH   = 3'd3;
    localparam logic [2:0] STAT_STALE  = 3'd4;
    localparam logic [2:0] STAT_RET    = 3'd5;
    localparam logic [2:0] STAT_REL    = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_SLOT_SIZE    = 1'b0;
    localparam logic CFG_ACTIVE_SLOTS = 1'b1;

    // Command broadcast to every slot cell during execution.
    typedef struct packed {
        logic        do_acq;
        logic        do_ret;
        logic        do_rel;
        logic [12:0] req_size;
        logic [7:0]  hslot;
        logic [31:0] hgen;
        logic [12:0] eff_size;
        logic [8:0]  eff_active;
    } t_cmd;

    // Data handed from one cell to the next along the chain.
    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [31:0] gen;
        logic        hit_live;
        logic [31:0] hit_refs;
        logic [12:0] hit_bytes;
    } t_chain;

endpackage

`default_nettype wire

// ===== sv/rslp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rslp_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [7:0]      i_index,
    input  wire rslp_pkg::t_cmd  i_cmd,
    input  wire logic            i_commit,
    input  wire rslp_pkg::t_chain i_chain,
    output rslp_pkg::t_chain     o_chain
);
    import rslp_pkg::*;

    logic        r_busy;
    logic [31:0] r_refs;
    logic [31:0] r_tag;
    logic [12:0] r_bytes;

    logic        w_active;
    logic        w_grant;
    logic        w_match;
    logic        w_live;
    logic [31:0] w_gen_next;

    // Local decisions for this slot.
    always_comb begin
        w_active   = {1'b0, i_index} < i_cmd.eff_active;
        w_grant    = i_cmd.do_acq && !i_chain.found && w_active && !r_busy;
        w_match    = i_cmd.hslot == i_index;
        w_live     = w_match && w_active && r_busy && (r_tag == i_cmd.hgen) &&
                     (r_refs != 32'd0) && (r_bytes <= i_cmd.eff_size);
        w_gen_next = (r_tag == 32'hFFFF_FFFF) ? 32'd1 : r_tag + 32'd1;
    end

    // Pass the chain on, claiming the grant or the handle hit here.
    always_comb begin
        o_chain = i_chain;
        if (w_grant) begin
            o_chain.found = 1'b1;
            o_chain.slot  = i_index;
            o_chain.gen   = w_gen_next;
        end
        if (w_match) begin
            o_chain.hit_live  = w_live;
            o_chain.hit_refs  = r_refs;
            o_chain.hit_bytes = r_bytes;
        end
    end

    // Slot state update when the transaction commits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_refs  <= 32'd0;
            r_tag   <= 32'd0;
            r_bytes <= 13'd0;
        end else if (i_commit) begin
            if (w_grant) begin
                r_busy  <= 1'b1;
                r_refs  <= 32'd1;
                r_tag   <= w_gen_next;
                r_bytes <= i_cmd.req_size;
            end else if (w_live && i_cmd.do_ret) begin
                if (r_refs != 32'hFFFF_FFFF) begin
                    r_refs <= r_refs + 32'd1;
                end
            end else if (w_live && i_cmd.do_rel) begin
                r_refs <= r_refs - 32'd1;
                if (r_refs == 32'd1) begin
                    r_bytes <= 13'd0;
                    r_busy  <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/refcounted_slot_lease_pool_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Slot lease pool with generation-tagged handles and reference counts.
// Input channel (i_in_valid / o_in_ready) carries one command transaction:
// acquire, retain, release, query or statistics read. Output channel
// (o_out_valid / i_out_ready) returns exactly one result transaction for
// each command, in order.
// The accepting edge registers the command; in the next cycle it runs
// through the row of slot cells, where a priority chain finds the lowest
// free slot and the addressed slot, and the update commits together with
// the result. No new command is accepted before the held one commits.
// A new command is accepted while a finished result still waits; if the
// receiver stalls, that command holds in execution until the output register
// frees, and the input side then stays not ready.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// once; the user must make them only while the pool is idle, as the block
// itself does not enforce it.
// Synchronous active-low reset empties every slot, clears all counters and
// sets slot size 64 and active slots 16; no clearing pass is needed.
module refcounted_slot_lease_pool_core #(
    parameter int NUM_SLOTS      = rslp_pkg::NUM_SLOTS_DEF,
    parameter int MAX_SLOT_BYTES = rslp_pkg::MAX_SLOT_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [12:0] i_request_size,
    input  wire logic [3:0]  i_handle_slot,
    input  wire logic [31:0] i_handle_generation,
    input  wire logic [2:0]  i_stat_select,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [3:0]       o_granted_slot,
    output logic [31:0]      o_new_generation,
    output logic [15:0]      o_data_offset,
    output logic [12:0]      o_held_size,
    output logic [31:0]      o_ref_count,
    output logic             o_live,
    output logic [31:0]      o_stat_value
);
    import rslp_pkg::*;

    // Configuration registers.
    logic [12:0] r_slot_size;
    logic [4:0]  r_active_slots;

    // Held command.
    logic        r_busy;
    logic [2:0]  r_kind;
    logic [12:0] r_req;
    logic [3:0]  r_hslot;
    logic [31:0] r_hgen;
    logic [2:0]  r_sel;

    // Counters.
    logic [31:0] r_stat [N_STATS];

    // Output register.
    logic        r_ov;
    logic [1:0]  r_status;
    logic [3:0]  r_gslot;
    logic [31:0] r_ngen;
    logic [15:0] r_offset;
    logic [12:0] r_held;
    logic [31:0] r_refc;
    logic        r_live;
    logic [31:0] r_statv;

    logic [1:0]  n_status;
    logic [3:0]  n_gslot;
    logic [31:0] n_ngen;
    logic [15:0] n_offset;
    logic [12:0] n_held;
    logic [31:0] n_refc;
    logic        n_live;
    logic [31:0] n_statv;

    logic [12:0] w_eff_size;
    logic [8:0]  w_eff_active;
    logic        w_oversize;
    logic        w_commit;
    logic        w_accept;
    logic [7:0]  w_off_slot;
    logic [20:0] w_product;
    logic [31:0] w_inuse_inc;
    t_cmd        w_cmd;
    t_chain      w_chain [NUM_SLOTS+1];
    t_chain      w_res;

    // Effective register values after clamping.
    always_comb begin
        if (r_slot_size == 13'd0) begin
            w_eff_size = 13'd1;
        end else if ({4'd0, r_slot_size} > 17'(MAX_SLOT_BYTES)) begin
            w_eff_size = 13'(MAX_SLOT_BYTES);
        end else begin
            w_eff_size = r_slot_size;
        end
        if (r_active_slots == 5'd0) begin
            w_eff_active = 9'd1;
        end else if ({4'd0, r_active_slots} > 9'(NUM_SLOTS)) begin
            w_eff_active = 9'(NUM_SLOTS);
        end else begin
            w_eff_active = {4'd0, r_active_slots};
        end
    end

    assign w_oversize = r_req > w_eff_size;
    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    assign w_commit   = r_busy && (!r_ov || i_out_ready);

    // Command broadcast to the cells.
    always_comb begin
        w_cmd.do_acq     = (r_kind == KIND_ACQUIRE) && !w_oversize;
        w_cmd.do_ret     = r_kind == KIND_RETAIN;
        w_cmd.do_rel     = r_kind == KIND_RELEASE;
        w_cmd.req_size   = r_req;
        w_cmd.hslot      = {4'd0, r_hslot};
        w_cmd.hgen       = r_hgen;
        w_cmd.eff_size   = w_eff_size;
        w_cmd.eff_active = w_eff_active;
    end

    // Row of slot cells; the lowest index sits at the head of the chain.
    assign w_chain[0] = '0;
    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        rslp_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (8'(k)),
            .i_cmd    (w_cmd),
            .i_commit (w_commit),
            .i_chain  (w_chain[k]),
            .o_chain  (w_chain[k+1])
        );
    end
    assign w_res = w_chain[NUM_SLOTS];

    // Payload offset of the granted or queried slot.
    assign w_off_slot  = (r_kind == KIND_ACQUIRE) ? w_res.slot : {4'd0, r_hslot};
    assign w_product   = {13'd0, w_off_slot} * {8'd0, w_eff_size};
    assign w_inuse_inc = r_stat[STAT_INUSE] + 32'd1;

    // Result of the held command.
    always_comb begin
        n_status = STATUS_OK;
        n_gslot  = 4'd0;
        n_ngen   = 32'd0;
        n_offset = 16'd0;
        n_held   = 13'd0;
        n_refc   = 32'd0;
        n_live   = 1'b0;
        n_statv  = 32'd0;
        unique case (r_kind)
            KIND_ACQUIRE: begin
                if (w_oversize) begin
                    n_status = STATUS_SIZE;
                end else if (w_res.found) begin
                    n_gslot  = w_res.slot[3:0];
                    n_ngen   = w_res.gen;
                    n_offset = w_product[15:0];
                end else begin
                    n_status = STATUS_FULL;
                end
            end
            KIND_RETAIN, KIND_RELEASE: begin
                if (!w_res.hit_live) begin
                    n_status = STATUS_STALE;
                end
            end
            KIND_QUERY: begin
                if (w_res.hit_live) begin
                    n_offset = w_product[15:0];
                    n_held   = w_res.hit_bytes;
                    n_refc   = w_res.hit_refs;
                    n_live   = 1'b1;
                end else begin
                    n_status = STATUS_STALE;
                end
            end
            KIND_STATS: begin
                if (r_sel < 3'(N_STATS)) begin
                    n_statv = r_stat[r_sel];
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_size    <= 13'd64;
            r_active_slots <= 5'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SLOT_SIZE) begin
                r_slot_size <= i_cfg_data;
            end else begin
                r_active_slots <= i_cfg_data[4:0];
            end
        end
    end

    // Command capture and execution handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_commit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_req   <= i_request_size;
            r_hslot <= i_handle_slot;
            r_hgen  <= i_handle_generation;
            r_sel   <= i_stat_select;
        end
        if (w_commit) begin
            r_status <= n_status;
            r_gslot  <= n_gslot;
            r_ngen   <= n_ngen;
            r_offset <= n_offset;
            r_held   <= n_held;
            r_refc   <= n_refc;
            r_live   <= n_live;
            r_statv  <= n_statv;
        end
    end

    // Statistic counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_STATS; s++) begin
                r_stat[s] <= 32'd0;
            end
        end else if (w_commit) begin
            if (r_kind == KIND_ACQUIRE && !w_oversize) begin
                if (w_res.found) begin
                    r_stat[STAT_ACQ]   <= r_stat[STAT_ACQ] + 32'd1;
                    r_stat[STAT_INUSE] <= w_inuse_inc;
                    if (w_inuse_inc > r_stat[STAT_HIGH]) begin
                        r_stat[STAT_HIGH] <= w_inuse_inc;
                    end
                end else begin
                    r_stat[STAT_FAIL] <= r_stat[STAT_FAIL] + 32'd1;
                end
            end else if (r_kind == KIND_RETAIN || r_kind == KIND_RELEASE) begin
                if (!w_res.hit_live) begin
                    r_stat[STAT_STALE] <= r_stat[STAT_STALE] + 32'd1;
                end else if (r_kind == KIND_RETAIN) begin
                    r_stat[STAT_RET] <= r_stat[STAT_RET] + 32'd1;
                end else begin
                    r_stat[STAT_REL] <= r_stat[STAT_REL] + 32'd1;
                    if (w_res.hit_refs == 32'd1) begin
                        r_stat[STAT_INUSE] <= r_stat[STAT_INUSE] - 32'd1;
                    end
                end
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_status;
    assign o_granted_slot   = r_gslot;
    assign o_new_generation = r_ngen;
    assign o_data_offset    = r_offset;
    assign o_held_size      = r_held;
    assign o_ref_count      = r_refc;
    assign o_live           = r_live;
    assign o_stat_value     = r_statv;

    // The occupancy never passes the high watermark or the pool size.
    a_inuse_le_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stat[STAT_INUSE] <= r_stat[STAT_HIGH])
        else $error("in-use count above high watermark");

    a_inuse_le_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stat[STAT_INUSE] <= 32'(NUM_SLOTS))
        else $error("in-use count above pool size");

    // An accepted transaction keeps the input not ready until its result commits.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && !o_in_ready))
        else $error("command lost after acceptance");

    // A committed result always lands in the output register.
    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_out_valid && !r_busy))
        else $error("committed result not presented");

endmodule

`default_nettype wire

// ===== tb/refcounted_slot_lease_pool_core_tb.sv =====
`timescale 1ns / 1ps

module refcounted_slot_lease_pool_core_tb;
    import rslp_pkg::*;

    localparam int         SLOTS       = 16;
    localparam int         MAX_BYTES   = 4096;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam logic [2:0] STAT_NONE   = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] req;
        logic [3:0]  hslot;
        logic [31:0] hgen;
        logic [2:0]  sel;
    } lease_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  gslot;
        logic [31:0] ngen;
        logic [15:0] offset;
        logic [12:0] held;
        logic [31:0] refs;
        logic        live;
        logic [31:0] stat;
    } lease_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        out_ready = 1'b0;
    lease_cmd_t  drv = '0;
    wire         in_ready;
    wire         out_valid;
    wire lease_result_t got;

    refcounted_slot_lease_pool_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_kind             (drv.kind),
        .i_request_size     (drv.req),
        .i_handle_slot      (drv.hslot),
        .i_handle_generation(drv.hgen),
        .i_stat_select      (drv.sel),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_status           (got.status),
        .o_granted_slot     (got.gslot),
        .o_new_generation   (got.ngen),
        .o_data_offset      (got.offset),
        .o_held_size        (got.held),
        .o_ref_count        (got.refs),
        .o_live             (got.live),
        .o_stat_value       (got.stat)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Pool state as the testbench expects it.
    logic        pool_busy [SLOTS];
    logic [31:0] pool_refs [SLOTS];
    logic [31:0] pool_tag  [SLOTS];
    logic [12:0] pool_bytes[SLOTS];
    logic [31:0] pool_stats[N_STATS];
    logic [12:0] cfg_slot_size = 13'd64;
    logic [4:0]  cfg_active = 5'd16;

    lease_cmd_t    pending_cmds[$];
    lease_result_t expected_results[$];
    bit            calm = 1'b0;
    int            mismatches = 0;
    int            checked = 0;
    int            kind_count[8];

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            pool_busy[s] = 1'b0;
            pool_refs[s] = '0;
            pool_tag[s] = '0;
            pool_bytes[s] = '0;
        end
        for (int k = 0; k < N_STATS; k++) pool_stats[k] = '0;
        for (int k = 0; k < 8; k++) kind_count[k] = 0;
    end

    function automatic int eff_size();
        if (cfg_slot_size == 0) return 1;
        if (cfg_slot_size > MAX_BYTES) return MAX_BYTES;
        return cfg_slot_size;
    endfunction

    function automatic int eff_active();
        if (cfg_active == 0) return 1;
        if (cfg_active > SLOTS) return SLOTS;
        return cfg_active;
    endfunction

    function automatic bit handle_live(logic [3:0] s, logic [31:0] g);
        if (s >= eff_active()) return 1'b0;
        return pool_busy[s] && pool_tag[s] == g && pool_refs[s] != 0 &&
               pool_bytes[s] <= eff_size();
    endfunction

    // Applies one command to the pool state and returns its result.
    function automatic lease_result_t apply_command(lease_cmd_t c);
        lease_result_t r;
        int            es;
        int            ea;
        bit            done;
        logic [31:0]   g;
        r = '0;
        es = eff_size();
        ea = eff_active();
        done = 1'b0;
        case (c.kind)
            KIND_ACQUIRE: begin
                if (c.req > es) begin
                    r.status = STATUS_SIZE;
                end else begin
                    for (int s = 0; s < ea; s++) begin
                        if (!done && !pool_busy[s]) begin
                            g = pool_tag[s] + 1;
                            if (g == 0) g = 1;
                            pool_busy[s] = 1'b1;
                            pool_refs[s] = 1;
                            pool_bytes[s] = c.req;
                            pool_tag[s] = g;
                            pool_stats[STAT_ACQ]++;
                            pool_stats[STAT_INUSE]++;
                            if (pool_stats[STAT_INUSE] > pool_stats[STAT_HIGH])
                                pool_stats[STAT_HIGH] = pool_stats[STAT_INUSE];
                            r.gslot = 4'(s);
                            r.ngen = g;
                            r.offset = 16'(s * es);
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        pool_stats[STAT_FAIL]++;
                        r.status = STATUS_FULL;
                    end
                end
            end
            KIND_RETAIN, KIND_RELEASE: begin
                if (!handle_live(c.hslot, c.hgen)) begin
                    pool_stats[STAT_STALE]++;
                    r.status = STATUS_STALE;
                end else if (c.kind == KIND_RETAIN) begin
                    if (pool_refs[c.hslot] != 32'hFFFF_FFFF) pool_refs[c.hslot]++;
                    pool_stats[STAT_RET]++;
                end else begin
                    pool_refs[c.hslot]--;
                    pool_stats[STAT_REL]++;
                    if (pool_refs[c.hslot] == 0) begin
                        pool_bytes[c.hslot] = '0;
                        pool_busy[c.hslot] = 1'b0;
                        pool_stats[STAT_INUSE]--;
                    end
                end
            end
            KIND_QUERY: begin
                if (handle_live(c.hslot, c.hgen)) begin
                    r.offset = 16'(c.hslot * es);
                    r.held = pool_bytes[c.hslot];
                    r.refs = pool_refs[c.hslot];
                    r.live = 1'b1;
                end else begin
                    r.status = STATUS_STALE;
                end
            end
            KIND_STATS: begin
                if (c.sel < N_STATS) r.stat = pool_stats[c.sel];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic lease_cmd_t make_cmd(logic [2:0] k, int req, int s, logic [31:0] g,
                                            logic [2:0] sel);
        lease_cmd_t c;
        c.kind = k;
        c.req = 13'(req);
        c.hslot = 4'(s);
        c.hgen = g;
        c.sel = sel;
        return c;
    endfunction

    // Random command shaped by the current pool state, mostly well formed.
    function automatic lease_cmd_t random_cmd();
        lease_cmd_t c;
        int         pick;
        int         s;
        int         es;
        c = $bits(lease_cmd_t)'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        es = eff_size();
        if (pick < 30) begin
            c.kind = KIND_ACQUIRE;
            case ($urandom_range(0, 9))
                0: c.req = 13'(es + $urandom_range(1, 3));
                1: c.req = 13'($urandom);
                2: c.req = 13'(es);
                default: c.req = 13'($urandom_range(0, es));
            endcase
        end else if (pick < 90) begin
            if (pick < 50) c.kind = KIND_RETAIN;
            else if (pick < 75) c.kind = KIND_RELEASE;
            else c.kind = KIND_QUERY;
            s = $urandom_range(0, SLOTS - 1);
            for (int t = 0; t < 8 && !pool_busy[s]; t++) s = $urandom_range(0, SLOTS - 1);
            c.hslot = 4'(s);
            case ($urandom_range(0, 9))
                0: c.hgen = pool_tag[s] + 1;
                1: c.hgen = pool_tag[s] - 1;
                2: ;
                default: c.hgen = pool_tag[s];
            endcase
        end else if (pick < 97) begin
            c.kind = KIND_STATS;
        end else begin
            c.kind = 3'($urandom_range(5, 7));
        end
        return c;
    endfunction

    // Driver: one command transaction at a time, with random idle bursts.
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(apply_command(drv));
                kind_count[drv.kind]++;
            end
            if (in_valid && !in_ready) begin
                in_valid <= 1'b1;
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
                in_gap <= $urandom_range(0, 13);
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                drv <= pending_cmds.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random receiver stalls and in-order comparison of results.
    int out_gap = 0;
    lease_result_t want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                checked++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result transaction %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (want !== got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d mismatch\n  expected %p\n  actual   %p",
                                     checked, want, got);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap <= $urandom_range(0, 13);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Checks are made at the falling edge, once the driver's updates have settled.
    task automatic wait_accepted();
        while (pending_cmds.size() > 0 || in_valid) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        wait_accepted();
        while (expected_results.size() > 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(logic idx, logic [12:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_SLOT_SIZE) cfg_slot_size = value;
        else cfg_active = value[4:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Random commands in small batches so handles follow the pool state.
    task automatic run_random(int count);
        while (count > 0) begin
            wait_accepted();
            for (int k = 0; k < 6 && count > 0; k++, count--)
                pending_cmds.push_back(random_cmd());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: basic lease life cycle, sizes, stale handles, stats, unused codes.
        pending_cmds.push_back(make_cmd(KIND_ACQUIRE, 0, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_ACQUIRE, 64, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_ACQUIRE, 65, 0, 0, 0));
        pending_cmds.push_back(make_cmd(KIND_ACQUIRE, 13'h1FFF, 15, '1, 7));
        pending_cmds.push_back(make_cmd(KIND_RETAIN, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_QUERY, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_RELEASE, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_RELEASE, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_QUERY, 0, 0, 1, 0));
        pending_cmds.push_back(make_cmd(KIND_RETAIN, 0, 1, 2, 0));
        pending_cmds.push_back(make_cmd(KIND_RETAIN, 0, 15, '1, 0));
        pending_cmds.push_back(make_cmd(KIND_QUERY, 0, 1, 1, 0));
        for (int k = 0; k < 8; k++)
            pending_cmds.push_back(make_cmd(KIND_STATS, 0, 0, 0, 3'(k)));
        pending_cmds.push_back(make_cmd(KIND_UNUSED, 13'h1FFF, 15, '1, STAT_NONE));
        pending_cmds.push_back(make_cmd(3'd5, 5, 3, 3, 3));
        pending_cmds.push_back(make_cmd(3'd6, 0, 1, 1, 1));
        wait_drained();

        // Fill the pool until it reports full.
        write_config(CFG_ACTIVE_SLOTS, 13'd16);
        write_config(CFG_SLOT_SIZE, 13'd64);
        for (int k = 0; k < 18; k++) pending_cmds.push_back(make_cmd(KIND_ACQUIRE, k, 0, 0, 0));
        wait_drained();
        run_random(120);
        wait_drained();

        // Sweep register settings, extremes included; busy slots carry over.
        write_config(CFG_SLOT_SIZE, 13'd0);
        write_config(CFG_ACTIVE_SLOTS, 13'd1);
        run_random(110);
        wait_drained();
        write_config(CFG_SLOT_SIZE, 13'd4096);
        write_config(CFG_ACTIVE_SLOTS, 13'd16);
        run_random(130);
        wait_drained();
        write_config(CFG_SLOT_SIZE, 13'h1FFF);
        write_config(CFG_ACTIVE_SLOTS, 13'd31);
        run_random(110);
        wait_drained();
        write_config(CFG_SLOT_SIZE, 13'd100);
        write_config(CFG_ACTIVE_SLOTS, 13'd0);
        run_random(110);
        wait_drained();
        write_config(CFG_SLOT_SIZE, 13'd1);
        write_config(CFG_ACTIVE_SLOTS, 13'd8);
        run_random(110);
        wait_drained();
        write_config(CFG_SLOT_SIZE, 13'd37);
        write_config(CFG_ACTIVE_SLOTS, 13'd5);
        run_random(110);
        wait_drained();

        // Final stretch with no random idle gaps on either side.
        write_config(CFG_SLOT_SIZE, 13'd4096);
        write_config(CFG_ACTIVE_SLOTS, 13'd16);
        calm = 1'b1;
        run_random(170);
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Checked %0d results: acquire %0d, retain %0d, release %0d, query %0d,",
                 checked, kind_count[KIND_ACQUIRE], kind_count[KIND_RETAIN],
                 kind_count[KIND_RELEASE], kind_count[KIND_QUERY]);
        $display("stats %0d, unused codes %0d, over eight pool settings; mismatches %0d.",
                 kind_count[KIND_STATS], kind_count[5] + kind_count[6] + kind_count[7],
                 mismatches);
        if (mismatches == 0)
            $display("refcounted_slot_lease_pool_core_tb OK");
        else
            $display("refcounted_slot_lease_pool_core_tb NOT OK");
        $finish;
    end

    // Run limit well beyond the slowest legal run.
    initial begin
        #5ms;
        $display("Timeout: %0d results still outstanding.", expected_results.size());
        $display("refcounted_slot_lease_pool_core_tb NOT OK");
        $finish;
    end

endmodule
